// File: rtl/wis_pkg.sv
// Package for the interscale soft threshold block: widths, codes and the
// job record passed from the front end to the back end. No dependencies.
package wis_pkg;

  localparam int NUM_BANDS  = 16;
  localparam int COEF_W     = 24;
  localparam int BAND_W     = 4;
  localparam int SEL_W      = 2;
  localparam int OUTC_W     = 3;
  localparam int BCNT_W     = 5;
  localparam int FRAC_BITS  = 12;
  localparam int DIV_STEPS  = FRAC_BITS;
  localparam int PROD_W     = COEF_W + FRAC_BITS + 1;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [BCNT_W-1:0] FS_DEC   = BCNT_W'(0);
  localparam logic [BCNT_W-1:0] NS_DEC   = BCNT_W'(1);
  localparam logic [BCNT_W-1:0] FS_UNDEC = BCNT_W'(2);
  localparam logic [BCNT_W-1:0] NS_UNDEC = BCNT_W'(3);
  localparam logic [BCNT_W-1:0] BANDS_RST = BCNT_W'(NUM_BANDS);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_COEF  = 1'b1;

  localparam logic CFG_UNDEC = 1'b0;
  localparam logic CFG_BANDS = 1'b1;

  localparam logic [SEL_W-1:0] SEL_N1 = 2'd0;
  localparam logic [SEL_W-1:0] SEL_N2 = 2'd1;
  localparam logic [SEL_W-1:0] SEL_P1 = 2'd2;
  localparam logic [SEL_W-1:0] SEL_P2 = 2'd3;

  typedef enum logic [OUTC_W-1:0] {
    OC_ZEROED  = 3'd0,
    OC_SCALED  = 3'd1,
    OC_KEPT    = 3'd2,
    OC_WRITTEN = 3'd3,
    OC_ERROR   = 3'd4
  } outcome_t;

  typedef struct packed {
    logic              undec;
    logic [BCNT_W-1:0] nb;
  } cfg_t;

  // a = |w - t1|, d = |t2 - t1|, a < d for a ramp job
  typedef struct packed {
    outcome_t                 outcome;
    logic signed [COEF_W-1:0] val;
    logic signed [COEF_W-1:0] w;
    logic [COEF_W-1:0]        a;
    logic [COEF_W-1:0]        d;
  } job_t;

endpackage

// File: rtl/wis_stream_if.sv
// Request and result channel interfaces with valid/ready handshake.
// Depends on wis_pkg.
interface wis_in_if import wis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [BAND_W-1:0]        band;
  logic signed [COEF_W-1:0] coeff;
  logic signed [COEF_W-1:0] partner_coeff;
  logic [SEL_W-1:0]         thr_select;
  logic signed [COEF_W-1:0] thr_value;

  modport source (output valid, req_type, band, coeff, partner_coeff, thr_select,
                  thr_value, input ready);
  modport sink   (input valid, req_type, band, coeff, partner_coeff, thr_select,
                  thr_value, output ready);
endinterface

interface wis_out_if import wis_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] out_coeff;
  logic [OUTC_W-1:0]        outcome;

  modport source (output valid, out_coeff, outcome, input ready);
  modport sink   (input valid, out_coeff, outcome, output ready);
endinterface

// File: rtl/wis_front.sv
// Front end: accepts requests, holds the threshold memories, classifies
// each request and pushes a job record. Depends on wis_pkg, wis_in_if.
module wis_front import wis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  wis_in_if.sink   in_ch,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     push,
  output job_t     job
);

  logic signed [COEF_W-1:0] n1_mem [NUM_BANDS];
  logic signed [COEF_W-1:0] n2_mem [NUM_BANDS];
  logic signed [COEF_W-1:0] p1_mem [NUM_BANDS];
  logic signed [COEF_W-1:0] p2_mem [NUM_BANDS];

  logic signed [COEF_W-1:0] n1_r, n2_r, p1_r, p2_r, pn1_r, pp1_r;
  logic signed [COEF_W-1:0] w_r, pw_r;
  logic va_r, wr_r, wr_ok_r, err_r, fine_r;

  logic en, acc, wr_en, band_ok, err_c, fine_c;
  logic [BCNT_W-1:0] bandx, fs, ns;
  logic [BAND_W-1:0] pband;
  logic signed [COEF_W:0] t1, t2, dif_a, dif_d;

  assign en    = !va_r || !q_full;
  assign in_ch.ready = en;
  assign acc   = in_ch.valid && en;

  assign bandx   = {1'b0, in_ch.band};
  assign fs      = cfg.undec ? FS_UNDEC : FS_DEC;
  assign ns      = cfg.undec ? NS_UNDEC : NS_DEC;
  assign fine_c  = bandx <= fs;
  assign err_c   = (bandx >= cfg.nb) || (fine_c && (bandx + ns >= cfg.nb));
  assign band_ok = bandx < BCNT_W'(NUM_BANDS);
  assign pband   = BAND_W'(bandx + ns);
  assign wr_en   = acc && (in_ch.req_type == REQ_WRITE) && band_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (in_ch.thr_select)
        SEL_N1: n1_mem[in_ch.band] <= in_ch.thr_value;
        SEL_N2: n2_mem[in_ch.band] <= in_ch.thr_value;
        SEL_P1: p1_mem[in_ch.band] <= in_ch.thr_value;
        SEL_P2: p2_mem[in_ch.band] <= in_ch.thr_value;
      endcase
    end
    if (en) begin
      n1_r    <= n1_mem[in_ch.band];
      n2_r    <= n2_mem[in_ch.band];
      p1_r    <= p1_mem[in_ch.band];
      p2_r    <= p2_mem[in_ch.band];
      pn1_r   <= n1_mem[pband];
      pp1_r   <= p1_mem[pband];
      w_r     <= in_ch.coeff;
      pw_r    <= in_ch.partner_coeff;
      wr_r    <= in_ch.req_type == REQ_WRITE;
      wr_ok_r <= band_ok;
      err_r   <= err_c;
      fine_r  <= fine_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= acc;
    end
  end

  always_comb begin
    job.outcome = OC_KEPT;
    job.val     = w_r;
    job.w       = w_r;
    t1          = {p1_r[COEF_W-1], p1_r};
    t2          = {p2_r[COEF_W-1], p2_r};
    if (wr_r) begin
      job.outcome = wr_ok_r ? OC_WRITTEN : OC_ERROR;
      job.val     = '0;
    end else if (err_r) begin
      job.outcome = OC_ERROR;
      job.val     = '0;
    end else if (w_r > n1_r && w_r < p1_r) begin
      job.outcome = OC_ZEROED;
      job.val     = '0;
    end else if (fine_r && !(pw_r < pn1_r || pw_r > pp1_r)) begin
      job.outcome = OC_ZEROED;
      job.val     = '0;
    end else if (w_r > p1_r && w_r < p2_r) begin
      job.outcome = OC_SCALED;
    end else if (w_r < n1_r && w_r > n2_r) begin
      job.outcome = OC_SCALED;
      t1          = {n1_r[COEF_W-1], n1_r};
      t2          = {n2_r[COEF_W-1], n2_r};
    end
    dif_a = {w_r[COEF_W-1], w_r} - t1;
    dif_d = t2 - t1;
    if (dif_d[COEF_W]) begin
      dif_a = -dif_a;
      dif_d = -dif_d;
    end
    job.a = dif_a[COEF_W-1:0];
    job.d = dif_d[COEF_W-1:0];
  end

  assign push = va_r && !q_full;

endmodule

// File: rtl/wis_fifo.sv
// Short job queue between front and back end.
// Depends on wis_pkg.
module wis_fifo import wis_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  job_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;

  assign full  = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("pop from empty queue");

endmodule

// File: rtl/wis_back.sv
// Back end: pipelined restoring divider for the ramp ratio, multiply,
// truncation and output register. Depends on wis_pkg, wis_out_if.
module wis_back import wis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      head,
  output logic      pop,
  wis_out_if.source out_ch
);

  typedef struct packed {
    outcome_t                 outcome;
    logic signed [COEF_W-1:0] val;
    logic signed [COEF_W-1:0] w;
    logic [COEF_W-1:0]        rem;
    logic [COEF_W-1:0]        d;
    logic [FRAC_BITS-1:0]     q;
  } div_t;

  function automatic div_t div_step(div_t x);
    div_t y;
    logic [COEF_W:0] rem2, dd;
    y    = x;
    rem2 = {x.rem, 1'b0};
    dd   = {1'b0, x.d};
    if (rem2 >= dd) begin
      y.rem = COEF_W'(rem2 - dd);
      y.q   = {x.q[FRAC_BITS-2:0], 1'b1};
    end else begin
      y.rem = rem2[COEF_W-1:0];
      y.q   = {x.q[FRAC_BITS-2:0], 1'b0};
    end
    return y;
  endfunction

  div_t st_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] sv_r;
  div_t head_d;

  logic                     mv_r;
  outcome_t                 moc_r;
  logic signed [COEF_W-1:0] mval_r;
  logic signed [PROD_W-1:0] prod_r, adj;

  logic                     ov_r;
  logic signed [COEF_W-1:0] oval_r;
  outcome_t                 ooc_r;
  logic adv;

  assign adv = !ov_r || out_ch.ready;
  assign pop = adv && !q_empty;

  always_comb begin
    head_d.outcome = head.outcome;
    head_d.val     = head.val;
    head_d.w       = head.w;
    head_d.rem     = head.a;
    head_d.d       = head.d;
    head_d.q       = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= div_step(head_d);
      for (int k = 1; k < DIV_STEPS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      moc_r  <= st_r[DIV_STEPS-1].outcome;
      mval_r <= st_r[DIV_STEPS-1].val;
      prod_r <= st_r[DIV_STEPS-1].w * $signed({1'b0, st_r[DIV_STEPS-1].q});
      ooc_r  <= moc_r;
      oval_r <= (moc_r == OC_SCALED) ? COEF_W'(adj >>> FRAC_BITS) : mval_r;
    end
  end

  assign adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      sv_r <= {sv_r[DIV_STEPS-2:0], pop};
      mv_r <= sv_r[DIV_STEPS-1];
      ov_r <= mv_r;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_coeff = oval_r;
  assign out_ch.outcome   = ooc_r;

  a_ramp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.outcome == OC_SCALED) |-> (head.a < head.d))
    else $error("ramp numerator not below denominator");
  a_nonramp_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mv_r && moc_r != OC_SCALED) |=> (oval_r == $past(mval_r)))
    else $error("non-ramp value altered");

endmodule

// File: rtl/wavelet_interscale_soft_threshold.sv
// Interscale soft thresholding of wavelet coefficients, top level.
// One request per cycle sustained while out_ch accepts results, as the
// 12-stage divider pipeline advances one stage per cycle unless stalled.
// Reset (rst_n, synchronous) clears pipeline valids, queue and config
// (decimated mode, 16 bands); threshold memories are not cleared.
// Depends on wis_pkg, wis_stream_if, wis_front, wis_fifo, wis_back.
module wavelet_interscale_soft_threshold import wis_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  wis_in_if.sink            in_ch,
  wis_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [BCNT_W-1:0] cfg_wdata
);

  logic              undec_r;
  logic [BCNT_W-1:0] bands_r;
  cfg_t cfg;
  logic push, pop, full, empty;
  job_t job_in, job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      undec_r <= 1'b0;
      bands_r <= BANDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_UNDEC: undec_r <= cfg_wdata[0];
        CFG_BANDS: bands_r <= cfg_wdata;
      endcase
    end
  end

  assign cfg.undec = undec_r;
  assign cfg.nb    = (bands_r > BCNT_W'(NUM_BANDS)) ? BCNT_W'(NUM_BANDS) : bands_r;

  wis_front u_front (
    .clk, .rst_n, .in_ch, .cfg, .q_full(full), .push, .job(job_in)
  );

  wis_fifo u_fifo (
    .clk, .rst_n, .push, .din(job_in), .full, .pop, .dout(job_out), .empty
  );

  wis_back u_back (
    .clk, .rst_n, .q_empty(empty), .head(job_out), .pop, .out_ch
  );

endmodule
